// ----- hw/rtl/fcull_pkg.sv -----
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants for the six-plane frustum cull test.
// ----------------------------------------------------------------------------
`default_nettype none

package fcull_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int REG_COUNT       = 6;
  localparam int PLANE_W         = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int COORD_W         = 16;
  localparam int RADIUS_W        = 15;
  localparam int IN_DATA_W       = 64;
  localparam int OUT_DATA_W      = 8;
  localparam int Q_DEPTH         = 4;

  // signed distance: 32-bit products, offset scaled by 2^14, sum of four
  localparam int PROD_W = 2 * COORD_W;
  localparam int DIST_W = PROD_W + 3;
  localparam int FRAC_SHIFT = 14;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE   = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_INSIDE    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [RADIUS_W-1:0] radius;
    logic                       last;
  } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fcull_front.sv -----
// ----------------------------------------------------------------------------
// fcull_front
// Input side: accepts requests, unpacks the point and queues it for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcull_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [fcull_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                               in_tlast,
  output logic                                    q_valid,
  output fcull_pkg::item_t                        q_item,
  input  wire logic                               q_pop
);
  import fcull_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t              mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  item_t              in_item;
  logic               push;

  always_comb begin
    in_item.x      = in_tdata[15:0];
    in_item.y      = in_tdata[31:16];
    in_item.z      = in_tdata[47:32];
    in_item.radius = in_tdata[62:48];
    in_item.last   = in_tlast;
  end

  assign in_tready = (count_r != CNT_W'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)  wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (q_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fcull_back.sv -----
// ----------------------------------------------------------------------------
// fcull_back
// Plane lanes: products, signed distance, per-plane flags and verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module fcull_back #(
  parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic [PLANE_COUNT-1:0][fcull_pkg::PLANE_W-1:0] planes,
  input  wire logic                                        q_valid,
  input  fcull_pkg::item_t                                 q_item,
  output logic                                             q_pop,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output fcull_pkg::verdict_t                              out_verdict
);
  import fcull_pkg::*;

  logic                              adv;
  logic                              a_valid_r;
  logic                              a_last_r;
  logic [RADIUS_W-1:0]               a_rad_r;
  logic signed [PROD_W-1:0]          px_r [PLANE_COUNT];
  logic signed [PROD_W-1:0]          py_r [PLANE_COUNT];
  logic signed [PROD_W-1:0]          pz_r [PLANE_COUNT];
  logic [PLANE_COUNT-1:0]            reached_r, cleared_r;
  logic [PLANE_COUNT-1:0]            reached_nxt, cleared_nxt;
  logic signed [DIST_W-1:0]          r_pos, r_neg;
  logic                              out_valid_r;
  verdict_t                          verdict_r, verdict_nxt;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  // stage A: one lane of three multipliers per plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_last_r <= q_item.last;
      a_rad_r  <= q_item.radius;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        px_r[p] <= $signed(planes[p][15:0])  * q_item.x;
        py_r[p] <= $signed(planes[p][31:16]) * q_item.y;
        pz_r[p] <= $signed(planes[p][47:32]) * q_item.z;
      end
    end
  end

  // stage B: distance sum, compare against +/- radius, fold into flags
  assign r_pos = $signed({{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, a_rad_r, {FRAC_SHIFT{1'b0}}});
  assign r_neg = -r_pos;

  always_comb begin
    logic signed [DIST_W-1:0] d;
    logic signed [DIST_W-1:0] off;
    reached_nxt = reached_r;
    cleared_nxt = cleared_r;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      off = $signed({{(DIST_W-COORD_W-FRAC_SHIFT){planes[p][63]}}, planes[p][63:48],
                     {FRAC_SHIFT{1'b0}}});
      d = DIST_W'(px_r[p]) + DIST_W'(py_r[p]) + DIST_W'(pz_r[p]) + off;
      if (d > r_neg)  reached_nxt[p] = 1'b1;
      if (!(d > r_pos)) cleared_nxt[p] = 1'b0;
    end
    if (reached_nxt != '1) begin
      verdict_nxt = VERDICT_OUTSIDE;
    end else if (cleared_nxt == '1) begin
      verdict_nxt = VERDICT_INSIDE;
    end else begin
      verdict_nxt = VERDICT_INTERSECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r   <= '0;
      cleared_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (adv && a_valid_r) begin
        if (a_last_r) begin
          reached_r <= '0;
          cleared_r <= '1;
        end else begin
          reached_r <= reached_nxt;
          cleared_r <= cleared_nxt;
        end
      end
      if (adv && a_valid_r && a_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r && a_last_r) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

  a_flags_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_valid_r && a_last_r) |=> (reached_r == '0 && cleared_r == '1))
    else $error("flags not restored after last item");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_valid_r && a_last_r) |=> out_valid_r)
    else $error("last item produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !adv) |=> a_valid_r)
    else $error("stage A item lost during stall");

endmodule

`default_nettype wire

// ----- hw/rtl/frustum_cull_test.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_test
// Six-plane view frustum classification of points, spheres and polygons.
//
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tdata: x, y, z, radius; tlast: last
// out_     out  out_tvalid/tready    tdata: verdict
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (64-bit plane word)
//
// One request per cycle while out_tready keeps up; the plane lanes run 18
// multipliers in parallel. A last item passes the queue and stage A to the
// verdict register. A 4-entry input queue lets in_tready stay high while a
// verdict waits on out_tready. Reset is synchronous; planes reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_test #(
  parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [15:0] point_x, [31:16] point_y, [47:32] point_z, [62:48] radius
  input  wire logic [fcull_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [1:0] verdict
  output logic [fcull_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [fcull_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcull_pkg::PLANE_W-1:0]      cfg_data
);
  import fcull_pkg::*;

  logic [PLANE_W-1:0]                   plane_r [REG_COUNT];
  logic [PLANE_COUNT-1:0][PLANE_W-1:0]  planes;
  logic                                 q_valid, q_pop;
  item_t                                q_item;
  verdict_t                             verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) plane_r[i] <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) plane_r[i] <= cfg_data;
      end
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    if (p < REG_COUNT) begin : g_reg
      assign planes[p] = plane_r[p];
    end else begin : g_zero
      assign planes[p] = '0;
    end
  end

  fcull_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  fcull_back #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .planes      (planes),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_verdict (verdict)
  );

  assign out_tdata = {{(OUT_DATA_W-2){1'b0}}, verdict};

endmodule

`default_nettype wire
